@@ hdl/wsfd_pkg.sv @@
// Package with the types and constants of the WebSocket frame deframer.
package wsfd_pkg;

  localparam logic [7:0] OpText   = 8'h81;
  localparam logic [7:0] OpBinary = 8'h82;
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  localparam logic [3:0] HdrShort = 4'd6;
  localparam logic [3:0] HdrExt16 = 4'd8;
  localparam logic [3:0] HdrExt64 = 4'd14;

  localparam logic [2:0] Ext16Bytes = 3'd2;
  // Eight extension bytes: the three-bit counter wraps to zero on the last one.
  localparam logic [2:0] Ext64Bytes = 3'd0;
  localparam logic [2:0] MaskBytes  = 3'd4;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LEN,
    PH_EXT,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER_BYTE = 2'd0,
    KIND_HEADER_DONE = 2'd1,
    KIND_PAYLOAD     = 2'd2,
    KIND_REJECT      = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic        is_last;
    logic        is_binary;
    logic [3:0]  header_size;
    logic [31:0] payload_length;
    logic [32:0] frame_size;
  } result_t;

endpackage

@@ hdl/wsfd_if.sv @@
// Valid/ready channel interfaces for the input bytes and the result items.
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        is_last;
  logic        is_binary;
  logic [3:0]  header_size;
  logic [31:0] payload_length;
  logic [32:0] frame_size;

  modport source (
    output valid, output kind, output out_byte, output is_last, output is_binary,
    output header_size, output payload_length, output frame_size, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input is_last, input is_binary,
    input header_size, input payload_length, input frame_size, output ready
  );
endinterface

@@ hdl/wsfd_parse.sv @@
// Header parser state and payload unmasking, one byte per accepted item.
module wsfd_parse
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] remaining_bytes, remaining_bytes_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_index, mask_index_next;
  logic        binary_flag, binary_flag_next;
  logic [3:0]  header_bytes, header_bytes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      byte_count      <= '0;
      length_accum    <= '0;
      remaining_bytes <= '0;
      mask_key        <= '0;
      mask_index      <= '0;
      binary_flag     <= 1'b0;
      header_bytes    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      length_accum    <= length_accum_next;
      remaining_bytes <= remaining_bytes_next;
      mask_key        <= mask_key_next;
      mask_index      <= mask_index_next;
      binary_flag     <= binary_flag_next;
      header_bytes    <= header_bytes_next;
    end
  end

  always_comb begin
    logic [2:0]  count_inc;
    logic [2:0]  need;
    logic [31:0] remain_dec;
    logic [7:0]  key_byte;

    phase_next           = phase;
    byte_count_next      = byte_count;
    length_accum_next    = length_accum;
    remaining_bytes_next = remaining_bytes;
    mask_key_next        = mask_key;
    mask_index_next      = mask_index;
    binary_flag_next     = binary_flag;
    header_bytes_next    = header_bytes;

    count_inc  = byte_count + 3'd1;
    need       = (header_bytes == HdrExt16) ? Ext16Bytes : Ext64Bytes;
    remain_dec = remaining_bytes - 32'd1;
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase

    res = '0;
    res.kind = KIND_HEADER_BYTE;

    case (phase)
      PH_LEN: begin
        res.is_binary     = binary_flag;
        byte_count_next   = '0;
        length_accum_next = '0;
        if (in_byte[6:0] == LenExt16) begin
          header_bytes_next = HdrExt16;
          phase_next        = PH_EXT;
        end else if (in_byte[6:0] == LenExt64) begin
          header_bytes_next = HdrExt64;
          phase_next        = PH_EXT;
        end else begin
          header_bytes_next = HdrShort;
          length_accum_next = {25'd0, in_byte[6:0]};
          phase_next        = PH_MASK;
        end
      end
      PH_EXT: begin
        res.is_binary     = binary_flag;
        length_accum_next = {length_accum[23:0], in_byte};
        byte_count_next   = count_inc;
        if (count_inc == need) begin
          byte_count_next = '0;
          phase_next      = PH_MASK;
        end
      end
      PH_MASK: begin
        res.is_binary   = binary_flag;
        mask_key_next   = {mask_key[23:0], in_byte};
        byte_count_next = count_inc;
        if (count_inc == MaskBytes) begin
          byte_count_next      = '0;
          mask_index_next      = '0;
          res.kind             = KIND_HEADER_DONE;
          res.header_size      = header_bytes;
          res.payload_length   = length_accum;
          res.frame_size       = {1'b0, length_accum} + {29'd0, header_bytes};
          remaining_bytes_next = length_accum;
          phase_next           = (length_accum == '0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.kind             = KIND_PAYLOAD;
        res.is_binary        = binary_flag;
        res.out_byte         = in_byte ^ key_byte;
        mask_index_next      = mask_index + 2'd1;
        remaining_bytes_next = remain_dec;
        if (remain_dec == '0) begin
          res.is_last = 1'b1;
          phase_next  = PH_FIRST;
        end
      end
      default: begin
        if (in_byte == OpText || in_byte == OpBinary) begin
          binary_flag_next = (in_byte == OpBinary);
          res.is_binary    = (in_byte == OpBinary);
          mask_key_next    = '0;
          byte_count_next  = '0;
          phase_next       = PH_LEN;
        end else begin
          res.kind   = KIND_REJECT;
          phase_next = PH_FIRST;
        end
      end
    endcase
  end

endmodule

@@ hdl/ws_frame_header_decode_unmask_top.sv @@
// WebSocket receive deframer: header decode and payload unmasking of a byte stream.
// When not stalled, the block takes one byte per clock cycle and returns exactly one result item
// for every byte, in the cycle after the byte is taken. The header parser updates
// its state and forms the result in the same cycle; the result then sits in a
// single output register. A new byte is accepted whenever that register is empty
// or its item is being taken in the same cycle, so the stream runs at full rate
// as long as the consumer keeps ready high.
module ws_frame_header_decode_unmask_top
  import wsfd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  wsfd_in_if.sink    in_ch,
  wsfd_out_if.source out_ch
);

  logic    accept;
  logic    out_valid;
  result_t res;
  result_t res_q;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  wsfd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.kind           = res_q.kind;
  assign out_ch.out_byte       = res_q.out_byte;
  assign out_ch.is_last        = res_q.is_last;
  assign out_ch.is_binary      = res_q.is_binary;
  assign out_ch.header_size    = res_q.header_size;
  assign out_ch.payload_length = res_q.payload_length;
  assign out_ch.frame_size     = res_q.frame_size;

endmodule

@@ bench/ws_frame_header_decode_unmask_top_tb.sv @@
// Self-checking testbench for the WebSocket frame deframer: header decode and unmasking.
`timescale 1ns / 100ps

module ws_frame_header_decode_unmask_top_tb;
  import wsfd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wsfd_in_if  in_ch ();
  wsfd_out_if out_ch ();

  ws_frame_header_decode_unmask_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Deframer state as seen from the byte stream.
  phase_t      rx_phase = PH_FIRST;
  int          hdr_count = 0;
  logic [31:0] len_accum = '0;
  logic [31:0] bytes_left = '0;
  logic [31:0] key_word = '0;
  logic [1:0]  key_pos = '0;
  logic        binary_frame = 1'b0;
  logic [3:0]  hdr_size = '0;

  result_t expected_results[$];

  int sent_bytes = 0;
  int results_checked = 0;
  int mismatches = 0;
  int headers_done = 0;
  int payload_unmasked = 0;
  int rejected_bytes = 0;
  int cycle_count = 0;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = KIND_HEADER_BYTE;
    case (rx_phase)
      PH_LEN: begin
        r.is_binary = binary_frame;
        hdr_count = 0;
        len_accum = '0;
        if (b[6:0] == LenExt16) begin
          hdr_size = HdrExt16;
          rx_phase = PH_EXT;
        end else if (b[6:0] == LenExt64) begin
          hdr_size = HdrExt64;
          rx_phase = PH_EXT;
        end else begin
          hdr_size = HdrShort;
          len_accum = {25'd0, b[6:0]};
          rx_phase = PH_MASK;
        end
      end
      PH_EXT: begin
        r.is_binary = binary_frame;
        len_accum = {len_accum[23:0], b};
        hdr_count++;
        if (hdr_count == ((hdr_size == HdrExt16) ? 2 : 8)) begin
          hdr_count = 0;
          rx_phase = PH_MASK;
        end
      end
      PH_MASK: begin
        r.is_binary = binary_frame;
        key_word = {key_word[23:0], b};
        hdr_count++;
        if (hdr_count == 4) begin
          hdr_count = 0;
          key_pos = '0;
          r.kind = KIND_HEADER_DONE;
          r.header_size = hdr_size;
          r.payload_length = len_accum;
          r.frame_size = {1'b0, len_accum} + {29'd0, hdr_size};
          bytes_left = len_accum;
          rx_phase = (len_accum == 0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.kind = KIND_PAYLOAD;
        r.is_binary = binary_frame;
        r.out_byte = b ^ key_word[8 * (3 - key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) begin
          r.is_last = 1'b1;
          rx_phase = PH_FIRST;
        end
      end
      default: begin
        if (b == OpText || b == OpBinary) begin
          binary_frame = (b == OpBinary);
          r.is_binary = binary_frame;
          key_word = '0;
          hdr_count = 0;
          rx_phase = PH_LEN;
        end else begin
          r.kind = KIND_REJECT;
          rx_phase = PH_FIRST;
        end
      end
    endcase
    return r;
  endfunction

  function automatic bit results_differ(input result_t a, input result_t b);
    return (a.kind !== b.kind) || (a.out_byte !== b.out_byte) || (a.is_last !== b.is_last) ||
      (a.is_binary !== b.is_binary) || (a.header_size !== b.header_size) ||
      (a.payload_length !== b.payload_length) || (a.frame_size !== b.frame_size);
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected kind=%0d byte=%02h last=%b binary=%b header=%0d length=%0d frame=%0d",
        want.kind, want.out_byte, want.is_last, want.is_binary, want.header_size,
        want.payload_length, want.frame_size);
      $display("  actual   kind=%0d byte=%02h last=%b binary=%b header=%0d length=%0d frame=%0d",
        seen.kind, seen.out_byte, seen.is_last, seen.is_binary, seen.header_size,
        seen.payload_length, seen.frame_size);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(deframe_byte(in_ch.in_byte));
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.kind = kind_t'(out_ch.kind);
        seen.out_byte = out_ch.out_byte;
        seen.is_last = out_ch.is_last;
        seen.is_binary = out_ch.is_binary;
        seen.header_size = out_ch.header_size;
        seen.payload_length = out_ch.payload_length;
        seen.frame_size = out_ch.frame_size;
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected", '0, seen);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          case (want.kind)
            KIND_HEADER_DONE: headers_done++;
            KIND_PAYLOAD:     payload_unmasked++;
            KIND_REJECT:      rejected_bytes++;
            default:          ;
          endcase
          if (results_differ(want, seen)) begin
            report_mismatch("result item mismatch", want, seen);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
        expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_checked != sent_bytes) @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == OpText || b == OpBinary);
    return b;
  endfunction

  task automatic send_frame(input logic binary, input logic mask_bit, input logic [6:0] len7,
                            input logic [63:0] ext_len, input logic [31:0] key, input int n);
    send_byte(binary ? OpBinary : OpText);
    send_byte({mask_bit, len7});
    if (len7 == LenExt16) begin
      for (int i = 1; i >= 0; i--) send_byte(ext_len[8 * i +: 8]);
    end else if (len7 == LenExt64) begin
      for (int i = 7; i >= 0; i--) send_byte(ext_len[8 * i +: 8]);
    end
    for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic test_rejected_first_bytes();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h83);
  endtask

  task automatic test_short_frame();
    send_frame(1'b0, 1'b1, 7'd2, 64'd0, 32'ha5c3_0f96, 2);
  endtask

  task automatic test_empty_frame();
    send_frame(1'b1, 1'b0, 7'd0, 64'd0, 32'hffff_ffff, 0);
  endtask

  task automatic test_ext16_frame();
    send_frame(1'b1, 1'b1, LenExt16, 64'd1, 32'h0000_0000, 1);
    wait_drained();
  endtask

  task automatic send_random_unit();
    int          pick;
    int          n;
    logic [6:0]  len7;
    logic [63:0] ext;
    logic [31:0] key;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_byte(noise_byte());
    end else if (pick < 14) begin
      // A frame-shaped run of bytes whose opcode is not accepted.
      repeat (6) send_byte(noise_byte());
    end else begin
      pick = $urandom_range(9);
      key = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom;
      ext = '0;
      case ($urandom_range(3))
        2: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(300, 126) : $urandom_range(20);
          ext = 64'(n);
          len7 = LenExt16;
        end
        3: begin
          n = $urandom_range(20);
          ext = {32'($urandom), 32'(n)};
          len7 = LenExt64;
        end
        default: begin
          len7 = ($urandom_range(7) == 0) ? 7'($urandom_range(125)) : 7'($urandom_range(12));
          n = len7;
        end
      endcase
      send_frame(1'($urandom_range(1)), 1'($urandom_range(1)), len7, ext, key, n);
    end
  endtask

  task automatic run_random_phase(input int idle, input int stall, input int n_items);
    int target;
    target = sent_bytes + n_items;
    idle_pct = idle;
    stall_pct <= stall;
    while (sent_bytes < target) send_random_unit();
    wait_drained();
  endtask

  task automatic test_output_hold();
    idle_pct = 0;
    stall_pct <= 0;
    hold_req <= ~hold_req;
    send_frame(1'b0, 1'b1, LenExt16, 64'd24, $urandom, 24);
    wait_drained();
  endtask

  // The frame never completes: the stream ends inside its payload.
  task automatic test_longest_length();
    send_frame(1'b0, 1'b1, LenExt64, {32'h8000_0001, 32'hffff_ffff}, 32'h1234_5678, 12);
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_rejected_first_bytes();
    test_short_frame();
    test_empty_frame();
    test_ext16_frame();
    run_random_phase(0, 0, 370);
    run_random_phase(78, 0, 370);
    test_output_hold();
    run_random_phase(0, 78, 370);
    run_random_phase(35, 35, 370);
    idle_pct = 0;
    stall_pct <= 0;
    test_longest_length();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d expected results never arrived.", expected_results.size());
    end
    $display("Checked %0d result items for %0d bytes: %0d headers, %0d payload bytes, %0d rejects.",
      results_checked, sent_bytes, headers_done, payload_unmasked, rejected_bytes);
    $display("Covered idle and stall mixes, a long output hold and a 32-bit maximum length.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/wsfd_pkg.sv
hdl/wsfd_if.sv
hdl/wsfd_parse.sv
hdl/ws_frame_header_decode_unmask_top.sv
bench/ws_frame_header_decode_unmask_top_tb.sv
